FILE: rtl/core/rtce_pkg.sv
// ----------------------------------------------------------------------------
// rtce_pkg: shared types and constants of the rectangle table engine
// Operation codes, the command record that passes from the front end to the
// scan engine, and the result record.
// ----------------------------------------------------------------------------
`default_nettype none
package rtce_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 64;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned CRD_W = 16;
  localparam int unsigned STEP_W = 11;
  localparam int unsigned RECT_W = 4 * CRD_W;
  localparam int unsigned CMDQ_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_CLEAR = 3'd1,
    OP_COLL  = 3'd2,
    OP_POINT = 3'd3,
    OP_ISECT = 3'd4
  } op_t;

  // One rectangle as held in the table.
  typedef struct packed {
    logic signed [CRD_W-1:0] l;
    logic signed [CRD_W-1:0] t;
    logic signed [CRD_W-1:0] r;
    logic signed [CRD_W-1:0] b;
  } rect_t;

  // A query as classified by the front end.
  typedef struct packed {
    logic [2:0]               op;
    logic [IDX_W-1:0]         index;
    rect_t                    rect;
    logic signed [STEP_W-1:0] step_x;
    logic signed [STEP_W-1:0] step_y;
    logic signed [CRD_W-1:0]  point_x;
    logic signed [CRD_W-1:0]  point_y;
  } cmd_t;

  typedef struct packed {
    logic             hori_hit;
    logic             vert_hit;
    logic             found;
    logic [IDX_W-1:0] found_index;
    logic             found_moving;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/core/rtce_ram.sv
// ----------------------------------------------------------------------------
// rtce_ram: generic single-port-write, single-port-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none
module rtce_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/rtce_front.sv
// ----------------------------------------------------------------------------
// rtce_front: command intake and classification
// Accepts items, applies writes and clears to the kind and valid flags and to
// the rectangle memory, answers them at once, and queues scan queries.
// ----------------------------------------------------------------------------
`default_nettype none
module rtce_front #(
  parameter int unsigned ENTRIES = rtce_pkg::ENTRIES_DEFAULT,
  localparam int unsigned AW = $clog2(ENTRIES)
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_take,
  input  wire logic [2:0]                      op,
  input  wire logic [rtce_pkg::IDX_W-1:0]      index,
  input  wire logic                            is_moving,
  input  wire rtce_pkg::rect_t                 rect,
  input  wire logic signed [rtce_pkg::STEP_W-1:0] step_x,
  input  wire logic signed [rtce_pkg::STEP_W-1:0] step_y,
  input  wire logic signed [rtce_pkg::CRD_W-1:0]  point_x,
  input  wire logic signed [rtce_pkg::CRD_W-1:0]  point_y,
  output logic                                 full,
  // table write port
  output logic                                 mem_we,
  output logic [AW-1:0]                        mem_waddr,
  output rtce_pkg::rect_t                      mem_wdata,
  output logic [ENTRIES-1:0]                   entry_valid,
  output logic [ENTRIES-1:0]                   entry_kind,
  // queue towards the scan engine
  output logic                                 cmd_valid,
  output rtce_pkg::cmd_t                       cmd,
  input  wire logic                            cmd_take,
  // every op ends with one result in order; non-scan ops carry an empty one
  output logic                                 fast_valid,
  input  wire logic                            back_idle
);

  localparam int unsigned QW = $clog2(rtce_pkg::CMDQ_DEPTH);

  rtce_pkg::cmd_t     q [rtce_pkg::CMDQ_DEPTH];
  logic [QW-1:0]      rd_ptr;
  logic [QW-1:0]      wr_ptr;
  logic [QW:0]        count;
  logic               is_scan;
  logic               in_range;
  logic               push_q;
  logic [AW-1:0]      slot;

  assign is_scan  = (op == rtce_pkg::OP_COLL) || (op == rtce_pkg::OP_POINT) ||
                    (op == rtce_pkg::OP_ISECT);
  assign in_range = {26'd0, index} < 32'(ENTRIES);
  assign slot     = AW'(index);
  // Writes and clears wait until no query is in flight so that results stay
  // in order and every scan sees the table as of its own acceptance.
  assign full     = (count == (QW+1)'(rtce_pkg::CMDQ_DEPTH)) ||
                    (!is_scan && (count != '0 || !back_idle));
  assign push_q   = in_take && is_scan;
  assign fast_valid = in_take && !is_scan;

  assign mem_we    = in_take && (op == rtce_pkg::OP_WRITE) && in_range;
  assign mem_waddr = slot;
  assign mem_wdata = rect;

  assign cmd_valid = count != '0;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      entry_kind  <= '0;
      rd_ptr      <= '0;
      wr_ptr      <= '0;
      count       <= '0;
    end else begin
      if (in_take && in_range) begin
        if (op == rtce_pkg::OP_WRITE) begin
          entry_valid[slot] <= 1'b1;
          entry_kind[slot]  <= is_moving;
        end else if (op == rtce_pkg::OP_CLEAR) begin
          entry_valid[slot] <= 1'b0;
        end
      end
      if (push_q) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QW+1)'(push_q) - (QW+1)'(cmd_take);
    end
  end

  always_ff @(posedge clk) begin
    if (push_q) begin
      q[wr_ptr] <= '{op: op, index: index, rect: rect, step_x: step_x,
                     step_y: step_y, point_x: point_x, point_y: point_y};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == (QW+1)'(rtce_pkg::CMDQ_DEPTH) |-> !push_q) else $error("queue overflow");
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid) else $error("take from empty queue");
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> count == '0) else $error("table write during scan");

endmodule
`default_nettype wire

FILE: rtl/core/rtce_scan.sv
// ----------------------------------------------------------------------------
// rtce_scan: table scan engine
// Runs one query over all entries, one rectangle read and compared a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rtce_scan #(
  parameter int unsigned ENTRIES = rtce_pkg::ENTRIES_DEFAULT,
  localparam int unsigned AW = $clog2(ENTRIES)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  input  wire rtce_pkg::cmd_t      cmd,
  output logic                     cmd_take,
  output logic [AW-1:0]            mem_raddr,
  input  wire rtce_pkg::rect_t     mem_rdata,
  input  wire logic [ENTRIES-1:0]  entry_valid,
  input  wire logic [ENTRIES-1:0]  entry_kind,
  output logic                     res_valid,
  output rtce_pkg::res_t           res,
  input  wire logic                res_ready,
  output logic                     idle
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t          state;
  rtce_pkg::cmd_t  c;
  logic [AW-1:0]   ra;        // address being read
  logic [AW-1:0]   ci;        // address of mem_rdata
  logic            cv;        // mem_rdata holds a live entry
  logic            last_rd;
  logic            hh, vh, sf, mf, xf;
  logic [AW-1:0]   si, mi, xi;

  logic signed [17:0] al, at, ar, ab, ol, ot, orr, ob, px, py, dx, dy;
  logic ent_ok, ov_g, ov_h, ov_v, in_pt, in_x;

  function automatic logic ovl(input logic signed [17:0] l1, t1, r1, b1,
                               input logic signed [17:0] l2, t2, r2, b2);
    ovl = !(t1 >= b2 || b1 <= t2 || r1 <= l2 || l1 >= r2);
  endfunction

  assign al  = 18'(c.rect.l);
  assign at  = 18'(c.rect.t);
  assign ar  = 18'(c.rect.r);
  assign ab  = 18'(c.rect.b);
  assign ol  = 18'(mem_rdata.l);
  assign ot  = 18'(mem_rdata.t);
  assign orr = 18'(mem_rdata.r);
  assign ob  = 18'(mem_rdata.b);
  assign px  = 18'(c.point_x);
  assign py  = 18'(c.point_y);
  assign dx  = 18'(c.step_x);
  assign dy  = 18'(c.step_y);

  assign ent_ok = cv && entry_valid[ci];
  assign ov_g   = ovl(al, at, ar, ab + 18'sd1, ol, ot, orr, ob);
  assign ov_h   = (dx < 0 && ovl(al + dx, at, ar, ab, ol, ot, orr, ob)) ||
                  (dx > 0 && ovl(al, at, ar + dx, ab, ol, ot, orr, ob));
  assign ov_v   = (dy < 0 && ovl(al, at + dy, ar, ab, ol, ot, orr, ob)) ||
                  (dy > 0 && ovl(al, at, ar, ab + dy, ol, ot, orr, ob));
  assign in_pt  = px > ol && px < orr && py > ot && py < ob;
  assign in_x   = !entry_kind[ci] && ({{(32-AW){1'b0}}, ci} != 32'(c.index)) &&
                  at <= ob && ab >= ot && ar >= ol && al <= orr;

  assign last_rd   = {{(32-AW){1'b0}}, ra} == 32'(ENTRIES - 1);
  assign mem_raddr = ra;
  assign cmd_take  = (state == S_IDLE) && cmd_valid;
  assign idle      = state == S_IDLE;
  assign res_valid = state == S_DONE;

  always_comb begin
    res = '0;
    case (c.op)
      rtce_pkg::OP_COLL: begin
        res.hori_hit = hh;
        res.vert_hit = vh;
      end
      rtce_pkg::OP_POINT: begin
        res.found        = sf || mf;
        res.found_index  = rtce_pkg::IDX_W'(sf ? si : (mf ? mi : '0));
        res.found_moving = !sf && mf;
      end
      rtce_pkg::OP_ISECT: begin
        res.found       = xf;
        res.found_index = rtce_pkg::IDX_W'(xi);
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cv    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          cv <= 1'b0;
          if (cmd_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cv <= !last_rd || !cv;
          if (cv && {{(32-AW){1'b0}}, ci} == 32'(ENTRIES - 1)) begin
            state <= S_DONE;
            cv    <= 1'b0;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      c  <= cmd;
      ra <= '0;
      hh <= 1'b0;
      vh <= 1'b0;
      sf <= 1'b0;
      mf <= 1'b0;
      xf <= 1'b0;
      si <= '0;
      mi <= '0;
      xi <= '0;
    end else if (state == S_SCAN) begin
      if (!last_rd) begin
        ra <= ra + 1'b1;
      end
      ci <= ra;
      if (ent_ok) begin
        if (ov_g || ov_v) vh <= 1'b1;
        if (ov_h) hh <= 1'b1;
        if (in_pt && entry_kind[ci]) begin
          mf <= 1'b1;
          mi <= ci;
        end
        if (in_pt && !entry_kind[ci]) begin
          sf <= 1'b1;
          si <= ci;
        end
        if (in_x && !xf) begin
          xf <= 1'b1;
          xi <= ci;
        end
      end
    end
  end

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> state == S_SCAN) else $error("scan did not start");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res)) else $error("result changed");
  a_state_hot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");

endmodule
`default_nettype wire

FILE: rtl/core/rect_table_collision_engine_core.sv
// ----------------------------------------------------------------------------
// rect_table_collision_engine_core: rectangle table collision engine
// Keeps a table of rectangles and answers collision, point and intersection
// queries by scanning the table.
// ----------------------------------------------------------------------------
// Usage. Items enter through a queue-style port: an item transfers on a rising
// edge where push is high and full is low. Every item produces exactly one
// result, presented on the result ports while empty is low and transferred
// where pop is high and empty is low. Results leave in item order.
// Writes and clears update the table in the cycle of their transfer and their
// all-zero result is ready in the next cycle. They are held off (full high)
// while a query is still queued or being scanned, so order is kept.
// A query (collision, point hit, intersection) passes a two-entry queue into
// the scan engine, which reads one rectangle per cycle from the table memory
// through its single read port and takes a new query only once the result
// of the last one has been handed on.
// The result register holds one result; when the receiver does not pop, the
// scan engine waits with its finished result and the front queue fills, then
// full rises. Reset clears all valid and kind flags, the queues and the
// result register; the rectangle memory is not cleared and no clearing pass
// is needed since only valid entries are used.
// ----------------------------------------------------------------------------
`default_nettype none
module rect_table_collision_engine_core #(
  parameter int unsigned ENTRIES = rtce_pkg::ENTRIES_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic [2:0]                          op,
  input  wire logic [rtce_pkg::IDX_W-1:0]          index,
  input  wire logic                                is_moving,
  input  wire logic signed [rtce_pkg::CRD_W-1:0]   left,
  input  wire logic signed [rtce_pkg::CRD_W-1:0]   top,
  input  wire logic signed [rtce_pkg::CRD_W-1:0]   right,
  input  wire logic signed [rtce_pkg::CRD_W-1:0]   bottom,
  input  wire logic signed [rtce_pkg::STEP_W-1:0]  step_x,
  input  wire logic signed [rtce_pkg::STEP_W-1:0]  step_y,
  input  wire logic signed [rtce_pkg::CRD_W-1:0]   point_x,
  input  wire logic signed [rtce_pkg::CRD_W-1:0]   point_y,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic                                     hori_hit,
  output logic                                     vert_hit,
  output logic                                     found,
  output logic [rtce_pkg::IDX_W-1:0]               found_index,
  output logic                                     found_moving
);

  localparam int unsigned AW = $clog2(ENTRIES);

  logic                  in_take;
  logic                  front_full;
  rtce_pkg::rect_t       in_rect;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  rtce_pkg::rect_t       mem_wdata;
  logic [AW-1:0]         mem_raddr;
  rtce_pkg::rect_t       mem_rdata;
  logic [ENTRIES-1:0]    entry_valid;
  logic [ENTRIES-1:0]    entry_kind;
  logic                  cmd_valid;
  rtce_pkg::cmd_t        cmd;
  logic                  cmd_take;
  logic                  fast_valid;
  logic                  back_idle;
  logic                  scan_valid;
  rtce_pkg::res_t        scan_res;
  logic                  scan_ready;
  logic                  out_valid;
  rtce_pkg::res_t        out_res;
  logic                  out_free;

  // The output register frees up in the same cycle it is popped.
  assign out_free   = !out_valid || pop;
  // A write or clear needs the output register for its own result.
  assign full       = front_full || (!out_free && !(op == rtce_pkg::OP_COLL ||
                      op == rtce_pkg::OP_POINT || op == rtce_pkg::OP_ISECT));
  assign in_take    = push && !full;
  // Writes only enter when the scanner is idle, so the two never compete.
  assign scan_ready = out_free;
  assign in_rect    = {left, top, right, bottom};

  rtce_front #(.ENTRIES(ENTRIES)) u_front (
    .clk, .rst, .in_take, .op, .index, .is_moving,
    .rect(in_rect),
    .step_x, .step_y, .point_x, .point_y,
    .full(front_full), .mem_we, .mem_waddr, .mem_wdata, .entry_valid, .entry_kind,
    .cmd_valid, .cmd, .cmd_take, .fast_valid, .back_idle
  );

  rtce_ram #(.WIDTH(rtce_pkg::RECT_W), .DEPTH(ENTRIES)) u_ram (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  rtce_scan #(.ENTRIES(ENTRIES)) u_scan (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take, .mem_raddr, .mem_rdata,
    .entry_valid, .entry_kind, .res_valid(scan_valid), .res(scan_res),
    .res_ready(scan_ready), .idle(back_idle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fast_valid || (scan_valid && scan_ready)) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fast_valid) begin
      out_res <= '0;
    end else if (scan_valid && scan_ready) begin
      out_res <= scan_res;
    end
  end

  assign empty        = !out_valid;
  assign hori_hit     = out_res.hori_hit;
  assign vert_hit     = out_res.vert_hit;
  assign found        = out_res.found;
  assign found_index  = out_res.found_index;
  assign found_moving = out_res.found_moving;

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(fast_valid && scan_valid)) else $error("two results at once");
  a_fill_free: assert property (@(posedge clk) disable iff (rst)
    fast_valid |-> out_free) else $error("result register overwritten");
  a_fast_empty: assert property (@(posedge clk) disable iff (rst)
    fast_valid |=> out_valid && out_res == '0) else $error("bad write result");

endmodule
`default_nettype wire
